// ===== hw/rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the C delimiter syntax checker: character
// codes, bracket kinds, error codes, lexical modes and stack control.
// ----------------------------------------------------------------------------
package dsc_pkg;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 4;
   localparam int KIND_W = 2;

   // Character codes that the lexer reacts to.
   localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;
   localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;

   // Bracket kinds held on the stack.
   localparam logic [KIND_W-1:0] K_PAREN   = 2'd0;
   localparam logic [KIND_W-1:0] K_BRACKET = 2'd1;
   localparam logic [KIND_W-1:0] K_BRACE   = 2'd2;

   // Error codes. A stray closer reports its kind plus one, an unclosed
   // opener reports its kind plus E_UNCLOSED_PAREN.
   localparam logic [CODE_W-1:0] E_NONE           = 4'd0;
   localparam logic [CODE_W-1:0] E_STRAY_PAREN    = 4'd1;
   localparam logic [CODE_W-1:0] E_UNCLOSED_PAREN = 4'd4;
   localparam logic [CODE_W-1:0] E_STRING         = 4'd7;
   localparam logic [CODE_W-1:0] E_CHAR           = 4'd8;
   localparam logic [CODE_W-1:0] E_COMMENT        = 4'd9;
   localparam logic [CODE_W-1:0] E_OVERFLOW       = 4'd10;

   typedef enum logic [8:0] {
      M_CODE       = 9'b000000001,
      M_SLASH      = 9'b000000010,
      M_LINE       = 9'b000000100,
      M_BLOCK      = 9'b000001000,
      M_BLOCK_STAR = 9'b000010000,
      M_STR        = 9'b000100000,
      M_STR_ESC    = 9'b001000000,
      M_CHR        = 9'b010000000,
      M_CHR_ESC    = 9'b100000000
   } lex_mode_type;

   // Shift command for the row of stack cells.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [KIND_W-1:0] push_kind;
   } stack_ctl_type;

endpackage

// ===== hw/rtl/c_delimiter_syntax_checker.sv =====
// ----------------------------------------------------------------------------
// c_delimiter_syntax_checker
// Checks brackets, literals and comments of C source text, one byte per item.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item, and the block takes one
// item per clock cycle; each result enters the output register and shows in
// the cycle after acceptance, and while it waits there it does not hold off
// the next byte as long as the sink takes it in the same cycle. The bracket
// stack is a row of NEST_DEPTH cells that all shift together on a push or pop,
// so the top of stack is always in the first cell and each byte is one mode
// update plus one shift. The result code is the first error seen in the current
// text (zero if none); an item with req_tlast set ends the text, reports the
// final check with rsp_tlast set, and clears all state for the next text.
module c_delimiter_syntax_checker
   import dsc_pkg::*;
#(
   parameter int NEST_DEPTH = 64
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] error_code, [7:4] zero
   output logic        rsp_tlast    // text_done
);

   stack_ctl_type       ctl;
   logic                take;
   logic [CODE_W-1:0]   result_code;
   logic [KIND_W-1:0]   cell_kind [NEST_DEPTH];

   logic                rsp_valid_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic                rsp_done_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   dsc_lexer #(
      .NEST_DEPTH (NEST_DEPTH)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .text_byte   (req_tdata),
      .end_marker  (req_tlast),
      .top_kind    (cell_kind[0]),
      .ctl         (ctl),
      .result_code (result_code)
   );

   for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
      logic [KIND_W-1:0] above;
      logic [KIND_W-1:0] below;

      if (i == 0) begin : g_top
         assign above = ctl.push_kind;
      end else begin : g_mid
         assign above = cell_kind[i-1];
      end
      if (i == NEST_DEPTH - 1) begin : g_last
         assign below = K_PAREN;
      end else begin : g_inner
         assign below = cell_kind[i+1];
      end

      dsc_stack_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_code_ff <= result_code;
         rsp_done_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - CODE_W){1'b0}}, rsp_code_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

// ===== hw/rtl/dsc_stack_cell.sv =====
// ----------------------------------------------------------------------------
// dsc_stack_cell
// One entry of the shifting bracket stack. On a push every cell takes the
// kind of its upper neighbor, on a pop that of its lower neighbor, so the
// top of stack always sits in the first cell.
// ----------------------------------------------------------------------------
module dsc_stack_cell
   import dsc_pkg::*;
(
   input  logic                clock,
   input  stack_ctl_type       ctl,
   input  logic [KIND_W-1:0]   from_above,
   input  logic [KIND_W-1:0]   from_below,
   output logic [KIND_W-1:0]   kind
);

   logic [KIND_W-1:0] kind_ff;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         kind_ff <= from_above;
      end else if (ctl.pop) begin
         kind_ff <= from_below;
      end
   end

   assign kind = kind_ff;

endmodule

// ===== hw/rtl/dsc_lexer.sv =====
// ----------------------------------------------------------------------------
// dsc_lexer
// Lexical mode machine, stack depth counter and sticky error. Decides the
// push or pop for the stack cells and forms the result code of each item.
// ----------------------------------------------------------------------------
module dsc_lexer
   import dsc_pkg::*;
#(
   parameter int NEST_DEPTH = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [BYTE_W-1:0]   text_byte,
   input  logic                end_marker,
   input  logic [KIND_W-1:0]   top_kind,
   output stack_ctl_type       ctl,
   output logic [CODE_W-1:0]   result_code
);

   localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(NEST_DEPTH);

   lex_mode_type        mode_ff, mode_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [CODE_W-1:0]   sticky_ff, sticky_in;

   logic                do_code;
   logic                is_open;
   logic                is_close;
   logic [KIND_W-1:0]   kind;
   logic                raise;
   logic [CODE_W-1:0]   raise_code;
   logic                push;
   logic                pop;
   logic [CODE_W-1:0]   final_code;
   logic [CODE_W-1:0]   step_sticky;

   always_comb begin
      mode_in    = mode_ff;
      do_code    = 1'b0;
      is_open    = 1'b0;
      is_close   = 1'b0;
      kind       = K_PAREN;
      raise      = 1'b0;
      raise_code = E_NONE;
      push       = 1'b0;
      pop        = 1'b0;

      unique case (mode_ff)
         M_CODE: begin
            do_code = 1'b1;
         end
         M_SLASH: begin
            if (text_byte == CH_SLASH) begin
               mode_in = M_LINE;
            end else if (text_byte == CH_STAR) begin
               mode_in = M_BLOCK;
            end else begin
               mode_in = M_CODE;
               do_code = 1'b1;
            end
         end
         M_LINE: begin
            if (text_byte == CH_NEWLINE) mode_in = M_CODE;
         end
         M_BLOCK: begin
            if (text_byte == CH_STAR) mode_in = M_BLOCK_STAR;
         end
         M_BLOCK_STAR: begin
            if (text_byte == CH_SLASH) begin
               mode_in = M_CODE;
            end else if (text_byte != CH_STAR) begin
               mode_in = M_BLOCK;
            end
         end
         M_STR: begin
            if (text_byte == CH_NEWLINE) begin
               raise = 1'b1; raise_code = E_STRING; mode_in = M_CODE;
            end else if (text_byte == CH_BACKSLASH) begin
               mode_in = M_STR_ESC;
            end else if (text_byte == CH_DQUOTE) begin
               mode_in = M_CODE;
            end
         end
         M_STR_ESC: begin
            if (text_byte == CH_NEWLINE) begin
               raise = 1'b1; raise_code = E_STRING; mode_in = M_CODE;
            end else begin
               mode_in = M_STR;
            end
         end
         M_CHR: begin
            if (text_byte == CH_NEWLINE) begin
               raise = 1'b1; raise_code = E_CHAR; mode_in = M_CODE;
            end else if (text_byte == CH_BACKSLASH) begin
               mode_in = M_CHR_ESC;
            end else if (text_byte == CH_SQUOTE) begin
               mode_in = M_CODE;
            end
         end
         M_CHR_ESC: begin
            if (text_byte == CH_NEWLINE) begin
               raise = 1'b1; raise_code = E_CHAR; mode_in = M_CODE;
            end else begin
               mode_in = M_CHR;
            end
         end
         default: begin
            mode_in = M_CODE;
            do_code = 1'b1;
         end
      endcase

      if (do_code) begin
         unique case (text_byte)
            CH_LPAREN:   begin is_open  = 1'b1; kind = K_PAREN;   end
            CH_LBRACKET: begin is_open  = 1'b1; kind = K_BRACKET; end
            CH_LBRACE:   begin is_open  = 1'b1; kind = K_BRACE;   end
            CH_RPAREN:   begin is_close = 1'b1; kind = K_PAREN;   end
            CH_RBRACKET: begin is_close = 1'b1; kind = K_BRACKET; end
            CH_RBRACE:   begin is_close = 1'b1; kind = K_BRACE;   end
            CH_DQUOTE:   mode_in = M_STR;
            CH_SQUOTE:   mode_in = M_CHR;
            CH_SLASH:    mode_in = M_SLASH;
            default:     ;
         endcase
      end

      if (is_open) begin
         if (depth_ff == FULL) begin
            raise = 1'b1; raise_code = E_OVERFLOW;
         end else begin
            push = 1'b1;
         end
      end
      if (is_close) begin
         if (depth_ff == '0 || top_kind != kind) begin
            raise      = 1'b1;
            raise_code = E_STRAY_PAREN + CODE_W'(kind);
         end else begin
            pop = 1'b1;
         end
      end
   end

   assign step_sticky = (raise && sticky_ff == E_NONE) ? raise_code : sticky_ff;

   // Checks at the end marker; the first held error takes precedence.
   always_comb begin
      if (sticky_ff != E_NONE) begin
         final_code = sticky_ff;
      end else if (mode_ff == M_STR || mode_ff == M_STR_ESC) begin
         final_code = E_STRING;
      end else if (mode_ff == M_CHR || mode_ff == M_CHR_ESC) begin
         final_code = E_CHAR;
      end else if (mode_ff == M_BLOCK || mode_ff == M_BLOCK_STAR) begin
         final_code = E_COMMENT;
      end else if (depth_ff != '0) begin
         final_code = E_UNCLOSED_PAREN + CODE_W'(top_kind);
      end else begin
         final_code = E_NONE;
      end
   end

   always_comb begin
      if (end_marker) begin
         sticky_in = E_NONE;
         depth_in  = '0;
      end else begin
         sticky_in = step_sticky;
         if (push) begin
            depth_in = depth_ff + DEPTH_W'(1);
         end else if (pop) begin
            depth_in = depth_ff - DEPTH_W'(1);
         end else begin
            depth_in = depth_ff;
         end
      end
   end

   assign result_code   = end_marker ? final_code : step_sticky;
   assign ctl.push      = take && !end_marker && push;
   assign ctl.pop       = take && !end_marker && pop;
   assign ctl.push_kind = kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_CODE;
         depth_ff  <= '0;
         sticky_ff <= E_NONE;
      end else if (take) begin
         mode_ff   <= end_marker ? M_CODE : mode_in;
         depth_ff  <= depth_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule
